### design/mlsw_pkg.sv
`timescale 1ns / 1ps

package mlsw_pkg;

    // Fixed geometry of the watchdog.
    localparam int LANES      = 4;
    localparam int LANE_BITS  = 2;
    localparam int COUNT_BITS = 32;
    localparam int TIME_BITS  = 48;
    localparam int LIMIT_BITS = 32;
    localparam int REARM_BITS = 16;
    localparam int ATT_BITS   = 17;
    localparam int ACT_BITS   = 3;

    localparam logic [ATT_BITS-1:0] ATTEMPT_MAX = {ATT_BITS{1'b1}};

    // Configuration port.
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_STALL_LIMIT = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_REARMS  = 8'd1;

    localparam logic [REARM_BITS-1:0] MAX_REARMS_RESET = 16'd3;

    // Request codes.
    localparam logic REQ_OBSERVE  = 1'b0;
    localparam logic REQ_REARMED  = 1'b1;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [TIME_BITS-1:0]  stamp_t;
    typedef logic [LANE_BITS-1:0]  lane_idx_t;

    typedef struct packed {
        logic              req_type;
        count_t            lane_count_0;
        count_t            lane_count_1;
        count_t            lane_count_2;
        count_t            lane_count_3;
        logic [ACT_BITS-1:0] active_lanes;
        logic              counts_present;
        stamp_t            now_ms;
    } item_t;

    typedef struct packed {
        logic      rearm_request;
        lane_idx_t stalled_lane;
        stamp_t    stalled_for_ms;
        count_t    stalled_at_count;
        logic      gave_up;
        logic      rearm_pending;
    } result_t;

    // What one lane finds for the current observation.
    typedef struct packed {
        logic   changed;
        logic   fresh;
        logic   stall;
        stamp_t elapsed;
    } lane_scan_t;

    // What the merging stage picks out of all lanes.
    typedef struct packed {
        logic      hit;
        lane_idx_t lane;
        stamp_t    elapsed;
        count_t    count;
    } pick_t;

endpackage

### design/mlsw_lane.sv
`timescale 1ns / 1ps

module mlsw_lane (
    input  mlsw_pkg::count_t                      count,
    input  mlsw_pkg::count_t                      last_count,
    input  mlsw_pkg::stamp_t                      changed_at,
    input  mlsw_pkg::stamp_t                      now_ms,
    input  logic [mlsw_pkg::LIMIT_BITS-1:0]       stall_limit,
    output mlsw_pkg::lane_scan_t                  scan
);
    import mlsw_pkg::*;

    stamp_t elapsed;

    // Elapsed time wraps modulo the stamp width, so a clock that runs
    // backwards looks like a very long stall.
    assign elapsed = now_ms - changed_at;

    always_comb
    begin
        scan.changed = (count != last_count);
        scan.fresh   = (count == '0) || (changed_at == '0);
        scan.elapsed = elapsed;
        scan.stall   = !scan.changed && !scan.fresh
                       && (elapsed >= TIME_BITS'(stall_limit));
    end

endmodule

### design/mlsw_merge.sv
`timescale 1ns / 1ps

module mlsw_merge (
    input  mlsw_pkg::lane_scan_t         scan [mlsw_pkg::LANES],
    input  mlsw_pkg::count_t             count [mlsw_pkg::LANES],
    input  logic [mlsw_pkg::LANES-1:0]   active,
    output mlsw_pkg::pick_t              pick,
    output logic [mlsw_pkg::LANES-1:0]   visit
);
    import mlsw_pkg::*;

    logic seen;

    // The first active stalled lane wins; lanes after it are not visited.
    always_comb
    begin
        seen         = 1'b0;
        pick.hit     = 1'b0;
        pick.lane    = '0;
        pick.elapsed = '0;
        pick.count   = '0;
        for (int i = 0; i < LANES; i++)
        begin
            visit[i] = active[i] && !seen;
            if (active[i] && scan[i].stall && !seen)
            begin
                pick.hit     = 1'b1;
                pick.lane    = LANE_BITS'(i);
                pick.elapsed = scan[i].elapsed;
                pick.count   = count[i];
            end
            seen = seen || (active[i] && scan[i].stall);
        end
    end

endmodule

### design/multi_lane_stall_watchdog.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// item      in         item_valid / item_stall  item (observe or rearmed transaction)
// result    out        result_valid / result_stall  result (one per item)
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item is taken per clock cycle while item_stall is low. All four lanes compare their counts and
// elapsed times side by side and a priority pick chooses the first stall, so
// the whole scan and state update fit in the cycle of acceptance. The result
// is registered in the output register, or in a one-entry skid register
// while the output is stalled; item_stall rises only once that skid entry
// is occupied. Reset is asynchronous and active low and takes effect at once;
// no clearing pass is needed.

module multi_lane_stall_watchdog (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  mlsw_pkg::item_t                      item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output mlsw_pkg::result_t                    result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mlsw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mlsw_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import mlsw_pkg::*;

    // Configuration registers.
    logic [LIMIT_BITS-1:0] stall_limit_reg;
    logic [REARM_BITS-1:0] max_rearms_reg;

    // Per-lane watch state.
    count_t last_count_reg [LANES];
    count_t last_count_next [LANES];
    stamp_t changed_at_reg [LANES];
    stamp_t changed_at_next [LANES];

    // Global state.
    logic [ATT_BITS-1:0] attempt_reg, attempt_next;
    logic                gave_up_reg, gave_up_next;
    logic                pending_reg, pending_next;
    lane_idx_t           rep_lane_reg, rep_lane_next;
    stamp_t              rep_for_reg, rep_for_next;
    count_t              rep_count_reg, rep_count_next;

    // Output register and skid entry.
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_reg, skid_next;

    logic                 accept;
    logic                 observe_en;
    logic                 rearm_req;
    logic [ATT_BITS-1:0]  attempt_sat;
    logic                 gives_up;
    logic [ACT_BITS-1:0]  lanes_clip;
    logic [LANES-1:0]     active;
    logic [LANES-1:0]     visit;
    count_t               lane_count [LANES];
    lane_scan_t           scan [LANES];
    pick_t                pick;
    result_t              res;

    assign cfg_ready  = 1'b1;
    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !skid_valid_reg;

    assign lane_count[0] = item.lane_count_0;
    assign lane_count[1] = item.lane_count_1;
    assign lane_count[2] = item.lane_count_2;
    assign lane_count[3] = item.lane_count_3;

    // Active lane count is clipped to the number of lanes built.
    assign lanes_clip = (item.active_lanes > ACT_BITS'(LANES))
                        ? ACT_BITS'(LANES) : item.active_lanes;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            active[i] = (ACT_BITS'(i) < lanes_clip);
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            mlsw_lane u_lane (
                .count       (lane_count[g]),
                .last_count  (last_count_reg[g]),
                .changed_at  (changed_at_reg[g]),
                .now_ms      (item.now_ms),
                .stall_limit (stall_limit_reg),
                .scan        (scan[g])
            );
        end
    endgenerate

    mlsw_merge u_merge (
        .scan   (scan),
        .count  (lane_count),
        .active (active),
        .pick   (pick),
        .visit  (visit)
    );

    // An observation is ignored outright when counts are absent, detection is
    // disabled, or the watchdog has given up or is waiting for a rearm.
    assign observe_en = accept && (item.req_type == REQ_OBSERVE) && item.counts_present
                        && (stall_limit_reg != '0) && !gave_up_reg && !pending_reg;

    assign attempt_sat = (attempt_reg == ATTEMPT_MAX) ? attempt_reg : attempt_reg + 1'b1;
    assign gives_up    = attempt_sat > ATT_BITS'(max_rearms_reg);

    always_comb
    begin
        last_count_next = last_count_reg;
        changed_at_next = changed_at_reg;
        attempt_next    = attempt_reg;
        gave_up_next    = gave_up_reg;
        pending_next    = pending_reg;
        rep_lane_next   = rep_lane_reg;
        rep_for_next    = rep_for_reg;
        rep_count_next  = rep_count_reg;
        rearm_req       = 1'b0;

        if (observe_en)
        begin
            // Visited lanes whose count changed or is fresh refresh their stamps; the
            // stalled lane itself is restamped only when a request goes out.
            for (int i = 0; i < LANES; i++)
            begin
                if (visit[i])
                begin
                    if (scan[i].changed)
                    begin
                        last_count_next[i] = lane_count[i];
                        changed_at_next[i] = item.now_ms;
                    end
                    else if (scan[i].fresh)
                    begin
                        changed_at_next[i] = item.now_ms;
                    end
                    else if (scan[i].stall && !gives_up)
                    begin
                        changed_at_next[i] = item.now_ms;
                    end
                end
            end
            if (pick.hit)
            begin
                attempt_next = attempt_sat;
                if (gives_up)
                begin
                    gave_up_next = 1'b1;
                end
                else
                begin
                    rep_lane_next  = pick.lane;
                    rep_for_next   = pick.elapsed;
                    rep_count_next = pick.count;
                    pending_next   = 1'b1;
                    rearm_req      = 1'b1;
                end
            end
        end
        else if (accept && (item.req_type == REQ_REARMED))
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (active[i])
                begin
                    last_count_next[i] = item.counts_present ? lane_count[i] : '0;
                    changed_at_next[i] = item.now_ms;
                end
            end
            pending_next = 1'b0;
        end
    end

    // The result shows the state as it stands after the item.
    always_comb
    begin
        res.rearm_request    = rearm_req;
        res.stalled_lane     = rep_lane_next;
        res.stalled_for_ms   = rep_for_next;
        res.stalled_at_count = rep_count_next;
        res.gave_up          = gave_up_next;
        res.rearm_pending    = pending_next;
    end

    // Output register with a one-entry skid behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_next       = res;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_limit_reg <= '0;
            max_rearms_reg  <= MAX_REARMS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_STALL_LIMIT)
            begin
                stall_limit_reg <= cfg_data[LIMIT_BITS-1:0];
            end
            else if (cfg_index == REG_MAX_REARMS)
            begin
                max_rearms_reg <= cfg_data[REARM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                last_count_reg[i] <= '0;
                changed_at_reg[i] <= '0;
            end
            attempt_reg    <= '0;
            gave_up_reg    <= 1'b0;
            pending_reg    <= 1'b0;
            rep_lane_reg   <= '0;
            rep_for_reg    <= '0;
            rep_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            last_count_reg <= last_count_next;
            changed_at_reg <= changed_at_next;
            attempt_reg    <= attempt_next;
            gave_up_reg    <= gave_up_next;
            pending_reg    <= pending_next;
            rep_lane_reg   <= rep_lane_next;
            rep_for_reg    <= rep_for_next;
            rep_count_reg  <= rep_count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Giving up is permanent until reset.
    a_gave_up_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        gave_up_reg |=> gave_up_reg)
        else $error("watchdog left the given-up state");

    // A result that raises a request must also show the request as pending.
    a_request_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.rearm_request) |-> result.rearm_pending)
        else $error("rearm request without pending flag");

    // The skid entry is only ever filled behind a held output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied with empty output register");

    // An observation taken while a request is pending leaves it pending.
    a_pending_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.req_type == REQ_OBSERVE) && pending_reg) |=> pending_reg)
        else $error("pending flag cleared by an observation");

endmodule
